// ===== src/rpcg_pkg.sv =====
// rpcg_pkg: shared types, register indexes and microcode rom for the rainbow pixel color generator
// no dependencies; used by rainbow_pixel_color_generator
`default_nettype none

package rpcg_pkg;

  localparam int SECTIONS_DEF    = 6;
  localparam int SOLID_WIDTH_DEF = 16;
  localparam int FADE_WIDTH_DEF  = 16;

  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPRESS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS_0_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS_2_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS_4_5 = 3'd4;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_SUM  = 3'd0;
  localparam step_t STEP_QUO  = 3'd1;
  localparam step_t STEP_REM  = 3'd2;
  localparam step_t STEP_FIX  = 3'd3;
  localparam step_t STEP_SECT = 3'd4;
  localparam step_t STEP_NUM  = 3'd5;
  localparam step_t STEP_RES  = 3'd6;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_END_IF_TICK,
    SEQ_END
  } seq_t;

  typedef struct packed {
    logic ld_acc;
    logic ld_quo;
    logic ld_rem;
    logic fix_rem;
    logic ld_sect;
    logic ld_num;
    logic ld_res;
    seq_t seq;
  } uword_t;

  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    w     = '0;
    w.seq = SEQ_NEXT;
    case (pc)
      STEP_SUM:  w.ld_acc  = 1'b1;
      STEP_QUO:  w.ld_quo  = 1'b1;
      STEP_REM:  w.ld_rem  = 1'b1;
      STEP_FIX: begin
        w.fix_rem = 1'b1;
        w.seq     = SEQ_END_IF_TICK;
      end
      STEP_SECT: w.ld_sect = 1'b1;
      STEP_NUM:  w.ld_num  = 1'b1;
      STEP_RES: begin
        w.ld_res = 1'b1;
        w.seq    = SEQ_END;
      end
      default:   w.seq = SEQ_END;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/rainbow_pixel_color_generator.sv =====
// rainbow_pixel_color_generator: scrolling rainbow with solid and linear fade sections
// microcoded sequencer over a small datapath; depends on rpcg_pkg
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------------
//   input   | in_valid, in_stall, in_data    | tick or pixel query transaction
//   output  | out_valid, out_stall, out_data | rgb color of a pixel query
//   config  | cfg_we, cfg_index, cfg_data    | register write, no read-back
//
// a tick runs 4 microcode steps and a pixel query 7, one step per cycle unless the last step waits at the output;
// the next transaction is accepted in the cycle of the last step
// the modulo by the rainbow length is a reciprocal multiply plus one correction step
// the pixel query's last step waits while a previous result is still stalled at the output
// synchronous active-low reset: position 0, speed and compress 1, colors 0
`default_nettype none

module rainbow_pixel_color_generator #(
  parameter int SECTIONS    = rpcg_pkg::SECTIONS_DEF,
  parameter int SOLID_WIDTH = rpcg_pkg::SOLID_WIDTH_DEF,
  parameter int FADE_WIDTH  = rpcg_pkg::FADE_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  rpcg_pkg::in_item_t              in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output rpcg_pkg::out_item_t                   out_data,
  input  wire                                   cfg_we,
  input  wire  [rpcg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [rpcg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SEC_WIDTH = SOLID_WIDTH + FADE_WIDTH;
  localparam int RB_LENGTH = SECTIONS * SEC_WIDTH;
  localparam int POS_W     = $clog2(RB_LENGTH);
  localparam int ACC_W     = ((POS_W > 24) ? POS_W : 24) + 1;
  localparam int RECIP_SH  = 32;
  localparam logic [RECIP_SH-1:0] RECIP = RECIP_SH'((64'd1 << RECIP_SH) / RB_LENGTH);
  localparam logic [ACC_W-1:0]    LEN_A = ACC_W'(RB_LENGTH);
  localparam logic [POS_W:0]      LEN_R = (POS_W+1)'(RB_LENGTH);

  localparam int SEC_W = $clog2(SECTIONS);
  localparam int OFF_W = (SEC_WIDTH > 1) ? $clog2(SEC_WIDTH) : 1;
  localparam int FO_W  = (FADE_WIDTH > 1) ? $clog2(FADE_WIDTH) : 1;
  localparam int FD_W  = $clog2(FADE_WIDTH + 1);
  localparam int NUM_W = FD_W + 8;
  localparam int DIV_SH = 2 * FD_W + 8;
  localparam int DIV_MW = DIV_SH + 1;
  localparam int DP_W   = DIV_MW + NUM_W;
  localparam logic [DIV_MW-1:0] DIV_M =
    DIV_MW'(((64'd1 << DIV_SH) + FADE_WIDTH - 1) / FADE_WIDTH);
  localparam logic [OFF_W-1:0] SOLID_O = OFF_W'(SOLID_WIDTH);
  localparam logic [FD_W-1:0]  FADE_D  = FD_W'(FADE_WIDTH);
  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTIONS - 1);

  // control and configuration state
  logic                  busy_r;
  rpcg_pkg::step_t       pc_r;
  logic                  out_valid_r;
  logic [POS_W-1:0]      pos_r;
  logic [7:0]            speed_r;
  logic [7:0]            compress_r;
  logic [47:0]           color_r [3];

  // datapath
  logic                  op_r;
  logic [15:0]           pix_r;
  logic [ACC_W-1:0]      acc_r;
  logic [ACC_W-1:0]      quo_r;
  logic [POS_W:0]        rem_r;
  logic [23:0]           left_r;
  logic [23:0]           right_r;
  logic                  solid_r;
  logic [FO_W-1:0]       fo_r;
  logic [NUM_W-1:0]      num_r  [3];
  logic [7:0]            base_r [3];
  rpcg_pkg::out_item_t   out_data_r;

  rpcg_pkg::uword_t      uw;
  logic                  go;
  logic                  finish;
  logic                  accept;
  logic                  out_valid_nxt;

  logic [23:0]           scaled;
  logic [ACC_W-1:0]      acc_nxt;
  logic [ACC_W+RECIP_SH-1:0] qprod;
  logic [ACC_W-1:0]      qlen;
  logic [ACC_W-1:0]      diff;
  logic [POS_W:0]        fix_v;

  logic [POS_W-1:0]      p_v;
  logic [SEC_W-1:0]      sec_v;
  logic [SEC_W-1:0]      nsec_v;
  logic [POS_W-1:0]      base_pos_v;
  logic [OFF_W-1:0]      off_v;
  logic [2:0]            s3;
  logic [2:0]            n3;
  logic [23:0]           left_v;
  logic [23:0]           right_v;

  logic [NUM_W-1:0]      num_v  [3];
  logic [7:0]            base_v [3];
  logic [7:0]            res_v  [3];

  // sequencer
  always_comb begin
    uw     = rpcg_pkg::ucode(pc_r);
    go     = busy_r && !(uw.ld_res && out_valid_r && out_stall);
    finish = go && ((uw.seq == rpcg_pkg::SEQ_END) ||
                    ((uw.seq == rpcg_pkg::SEQ_END_IF_TICK) && (op_r == rpcg_pkg::OP_TICK)));
    accept = in_valid && !in_stall;
    out_valid_nxt = (go && uw.ld_res) || (out_valid_r && out_stall);
  end

  assign in_stall  = busy_r && !finish;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sum, reciprocal quotient, remainder and correction
  always_comb begin
    scaled  = 24'(pix_r) * 24'(compress_r);
    if (op_r == rpcg_pkg::OP_TICK) begin
      acc_nxt = ACC_W'(pos_r) + ACC_W'(speed_r);
    end else begin
      acc_nxt = ACC_W'(pos_r) + ACC_W'(scaled);
    end
    qprod = (ACC_W+RECIP_SH)'(acc_r) * (ACC_W+RECIP_SH)'(RECIP);
    qlen  = quo_r * LEN_A;
    diff  = acc_r - qlen;
    fix_v = (rem_r >= LEN_R) ? (rem_r - LEN_R) : rem_r;
  end

  // section, offset and the two colors
  always_comb begin
    p_v        = rem_r[POS_W-1:0];
    sec_v      = '0;
    base_pos_v = '0;
    for (int k = 1; k < SECTIONS; k++) begin
      if (p_v >= POS_W'(k * SEC_WIDTH)) begin
        sec_v      = SEC_W'(k);
        base_pos_v = POS_W'(k * SEC_WIDTH);
      end
    end
    off_v   = OFF_W'(p_v - base_pos_v);
    nsec_v  = (sec_v == LAST_SEC) ? '0 : sec_v + 1'b1;
    s3      = 3'(sec_v);
    n3      = 3'(nsec_v);
    left_v  = s3[0] ? color_r[s3[2:1]][47:24] : color_r[s3[2:1]][23:0];
    right_v = n3[0] ? color_r[n3[2:1]][47:24] : color_r[n3[2:1]][23:0];
  end

  // blend numerator and final divide, one lane per channel
  always_comb begin
    logic [7:0]      lv;
    logic [7:0]      rv;
    logic            keep;
    logic            rising;
    logic [FD_W-1:0] fd;
    logic [DP_W-1:0] dp;
    lv = '0; rv = '0; keep = 1'b0; rising = 1'b0; fd = '0; dp = '0;
    for (int c = 0; c < 3; c++) begin
      lv     = left_r[8*(2-c) +: 8];
      rv     = right_r[8*(2-c) +: 8];
      keep   = solid_r || (lv == rv);
      rising = lv < rv;
      fd     = FADE_D - FD_W'(fo_r);
      if (keep) begin
        num_v[c] = '0;
      end else if (rising) begin
        num_v[c] = NUM_W'(fo_r) * NUM_W'(rv - lv);
      end else begin
        num_v[c] = NUM_W'(fd) * NUM_W'(lv - rv);
      end
      base_v[c] = (keep || rising) ? lv : rv;
      dp        = DP_W'(num_r[c]) * DP_W'(DIV_M);
      res_v[c]  = base_r[c] + dp[DIV_SH +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= rpcg_pkg::STEP_SUM;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      speed_r     <= 8'd1;
      compress_r  <= 8'd1;
      color_r[0]  <= '0;
      color_r[1]  <= '0;
      color_r[2]  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        busy_r <= 1'b1;
        pc_r   <= rpcg_pkg::STEP_SUM;
      end else if (finish) begin
        busy_r <= 1'b0;
      end else if (go) begin
        pc_r <= pc_r + 1'b1;
      end
      if (go && uw.fix_rem && (op_r == rpcg_pkg::OP_TICK)) begin
        pos_r <= fix_v[POS_W-1:0];
      end
      if (cfg_we) begin
        case (cfg_index)
          rpcg_pkg::REG_SPEED:      speed_r    <= cfg_data[7:0];
          rpcg_pkg::REG_COMPRESS:   compress_r <= cfg_data[7:0];
          rpcg_pkg::REG_COLORS_0_1: color_r[0] <= cfg_data;
          rpcg_pkg::REG_COLORS_2_3: color_r[1] <= cfg_data;
          rpcg_pkg::REG_COLORS_4_5: color_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.op;
      pix_r <= in_data.pixel_index;
    end
    if (go && uw.ld_acc) begin
      acc_r <= acc_nxt;
    end
    if (go && uw.ld_quo) begin
      quo_r <= qprod[RECIP_SH +: ACC_W];
    end
    if (go && uw.ld_rem) begin
      rem_r <= diff[POS_W:0];
    end
    if (go && uw.fix_rem) begin
      rem_r <= fix_v;
    end
    if (go && uw.ld_sect) begin
      left_r  <= left_v;
      right_r <= right_v;
      solid_r <= off_v < SOLID_O;
      fo_r    <= FO_W'(off_v - SOLID_O);
    end
    if (go && uw.ld_num) begin
      for (int c = 0; c < 3; c++) begin
        num_r[c]  <= num_v[c];
        base_r[c] <= base_v[c];
      end
    end
    if (go && uw.ld_res) begin
      out_data_r.red   <= res_v[0];
      out_data_r.green <= res_v[1];
      out_data_r.blue  <= res_v[2];
    end
  end

endmodule

`default_nettype wire
